@@ design/jsu_pkg.sv @@
// jsu_pkg: shared types and constants for the json string unescape block
// holds the decode mode enum, the result group struct and character codes
// no dependencies
package jsu_pkg;

    // most bytes one input byte can produce
    localparam int MaxResults = 5;
    localparam int CountW     = $clog2(MaxResults + 1);

    // escape decoding modes
    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } jsu_mode_t;

    // group of decoded bytes caused by one input request
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [CountW-1:0]          count;
        logic                       str_end;
    } jsu_group_t;

    // input characters
    localparam logic [7:0] CharBackslash = 8'h5C;
    localparam logic [7:0] CharU         = 8'h75;
    localparam logic [7:0] CharN         = 8'h6E;
    localparam logic [7:0] CharT         = 8'h74;
    localparam logic [7:0] CharR         = 8'h72;
    localparam logic [7:0] CharB         = 8'h62;
    localparam logic [7:0] CharF         = 8'h66;

    // decoded control characters
    localparam logic [7:0] CtrlLf = 8'h0A;
    localparam logic [7:0] CtrlHt = 8'h09;
    localparam logic [7:0] CtrlCr = 8'h0D;
    localparam logic [7:0] CtrlBs = 8'h08;
    localparam logic [7:0] CtrlFf = 8'h0C;

    // nonzero unicode escapes below this value decode to one byte
    localparam logic [15:0] AsciiLimit = 16'd128;

endpackage

@@ design/jsu_decode.sv @@
// jsu_decode: escape state machine, decodes one input byte into a result group
// keeps decode mode, hex digit count and the collected hex digits
// depends on jsu_pkg
module jsu_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output jsu_pkg::jsu_group_t grp
);
    import jsu_pkg::*;

    jsu_mode_t   mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [7:0]  chars_reg [3];
    logic        wr_en;
    logic [4:0]  hv;
    logic [4:0]  hv0, hv1, hv2;
    logic [15:0] code;

    // hex digit value, bit 4 flags a valid digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // append one byte to a group
    function automatic jsu_group_t put_byte(input jsu_group_t g, input logic [7:0] b);
        jsu_group_t r;
        r = g;
        r.bytes[r.count] = b;
        r.count = r.count + 1'b1;
        return r;
    endfunction

    assign hv   = hex_value(in_byte);
    assign hv0  = hex_value(chars_reg[0]);
    assign hv1  = hex_value(chars_reg[1]);
    assign hv2  = hex_value(chars_reg[2]);
    assign code = {hv0[3:0], hv1[3:0], hv2[3:0], hv[3:0]};

    // next state and result group
    always_comb
    begin
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        wr_en       = 1'b0;
        grp.bytes   = '0;
        grp.count   = '0;
        grp.str_end = in_last;
        unique case (mode_reg)
            MODE_ESCAPE:
            begin
                mode_next = MODE_PLAIN;
                case (in_byte)
                    CharN: grp = put_byte(grp, CtrlLf);
                    CharT: grp = put_byte(grp, CtrlHt);
                    CharR: grp = put_byte(grp, CtrlCr);
                    CharB: grp = put_byte(grp, CtrlBs);
                    CharF: grp = put_byte(grp, CtrlFf);
                    CharU:
                    begin
                        if (in_last)
                            grp = put_byte(grp, CharU);
                        else
                        begin
                            mode_next = MODE_HEX;
                            cnt_next  = '0;
                        end
                    end
                    default: grp = put_byte(grp, in_byte);
                endcase
            end
            MODE_HEX:
            begin
                if (!hv[4])
                begin
                    // failed escape: flush digits, then handle byte as plain text
                    grp = put_byte(grp, CharU);
                    for (int k = 0; k < 3; k++)
                        if (2'(k) < cnt_reg)
                            grp = put_byte(grp, chars_reg[k]);
                    cnt_next = '0;
                    if (in_byte == CharBackslash && !in_last)
                        mode_next = MODE_ESCAPE;
                    else
                    begin
                        mode_next = MODE_PLAIN;
                        grp = put_byte(grp, in_byte);
                    end
                end
                else if (cnt_reg != 2'd3)
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    // string ends mid escape: flush digits including this one
                    if (in_last)
                    begin
                        grp = put_byte(grp, CharU);
                        for (int k = 0; k < 3; k++)
                        begin
                            if (2'(k) < cnt_reg)
                                grp = put_byte(grp, chars_reg[k]);
                            else if (2'(k) == cnt_reg)
                                grp = put_byte(grp, in_byte);
                        end
                    end
                end
                else
                begin
                    // fourth digit completes the escape
                    if (code != '0 && code < AsciiLimit)
                        grp = put_byte(grp, code[7:0]);
                    else
                    begin
                        grp = put_byte(grp, CharU);
                        for (int k = 0; k < 3; k++)
                            grp = put_byte(grp, chars_reg[k]);
                        grp = put_byte(grp, in_byte);
                    end
                    mode_next = MODE_PLAIN;
                    cnt_next  = '0;
                end
            end
            default:
            begin
                mode_next = MODE_PLAIN;
                if (in_byte == CharBackslash && !in_last)
                    mode_next = MODE_ESCAPE;
                else
                    grp = put_byte(grp, in_byte);
            end
        endcase
        if (in_last)
        begin
            mode_next = MODE_PLAIN;
            cnt_next  = '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    // collected hex digits
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
            chars_reg[cnt_reg] <= in_byte;
    end

endmodule

@@ design/jsu_serializer.sv @@
// jsu_serializer: result register that holds a decoded group and sends it
// out one byte per cycle while out_ready is high, shifting the group down as bytes are taken
// depends on jsu_pkg
module jsu_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  jsu_pkg::jsu_group_t grp,
    output logic                can_load,
    output logic [7:0]          out_byte,
    output logic                run_last,
    output logic                string_end,
    output logic                out_valid,
    input  logic                out_ready
);
    import jsu_pkg::*;

    logic [MaxResults-1:0][7:0] bytes_reg;
    logic [CountW-1:0]          rem_reg;
    logic                       end_reg;
    logic                       pop;
    logic                       one_left;

    assign one_left   = (rem_reg == CountW'(1));
    assign out_valid  = (rem_reg != '0);
    assign pop        = out_valid && out_ready;
    assign can_load   = !out_valid || (one_left && out_ready);
    assign out_byte   = bytes_reg[0];
    assign run_last   = one_left;
    assign string_end = one_left && end_reg;

    // remaining count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else if (load && grp.count != '0)
            rem_reg <= grp.count;
        else if (pop)
            rem_reg <= rem_reg - 1'b1;
    end

    // group bytes, oldest at the bottom
    always_ff @(posedge clk)
    begin
        if (load && grp.count != '0)
        begin
            bytes_reg <= grp.bytes;
            end_reg   <= grp.str_end;
        end
        else if (pop)
            bytes_reg <= {8'h00, bytes_reg[MaxResults-1:1]};
    end

endmodule

@@ design/json_string_unescape_core.sv @@
// json_string_unescape_core: streaming unescape of a json string body
// output: registered, drained one byte per cycle while out_ready is high
// throughput: one input byte per cycle while out_ready is high and each byte
// yields one result; a larger group holds the input until its last byte is taken
// reset: asynchronous active low, returns to plain text mode, no results pending
module json_string_unescape_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_end,
    output logic       out_valid,
    input  logic       out_ready
);
    import jsu_pkg::*;

    jsu_group_t grp;
    logic       accept;

    assign accept = in_valid && in_ready;

    // escape decoding
    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .grp     (grp)
    );

    // result register and output sequencing
    jsu_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .grp        (grp),
        .can_load   (in_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    // end of string always yields a result
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> out_valid)
        else $error("string end produced no result");

    // input held while a multi-byte group drains
    a_hold_during_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> !in_ready)
        else $error("input taken with results still pending");

    // string end marks only the last byte of a group
    a_end_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string end flagged before last byte of group");

endmodule

@@ bench/json_string_unescape_core_test.sv @@
// json_string_unescape_core_test: self-checking bench for the json string unescape core
// drives escaped string bytes over valid/ready and checks every decoded byte against
// a cycle-free decoder kept here; depends on jsu_pkg and json_string_unescape_core
module json_string_unescape_core_test;

    import jsu_pkg::*;

    localparam logic [7:0] ChDigit0 = 8'h30;
    localparam logic [7:0] ChDigit9 = 8'h39;
    localparam logic [7:0] ChUpperA = 8'h41;
    localparam logic [7:0] ChUpperF = 8'h46;
    localparam logic [7:0] ChLowerA = 8'h61;
    localparam logic [7:0] ChLowerF = 8'h66;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChSlash  = 8'h2F;

    // one escaped input byte waiting to be sent
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hold;
    } esc_req_t;

    // one decoded byte the core should return
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       str_end;
    } dec_byte_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic [7:0] in_byte    = 8'h00;
    logic       in_last    = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    logic       out_valid;
    logic       out_ready  = 1'b0;

    esc_req_t   escaped_q [$];
    dec_byte_t  decoded_q [$];
    esc_req_t   next_req;
    dec_byte_t  want;
    int         send_idle     = 10;
    int         recv_idle     = 75;
    int         mismatch_count = 0;

    // decoder state
    jsu_mode_t   dec_mode  = MODE_PLAIN;
    int unsigned dig_count = 0;
    logic [7:0]  digits [3];
    dec_byte_t   step_q [$];

    json_string_unescape_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    // clock, period 2
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // decoder
    // ------------------------------------------------------------------

    function automatic int hex_value(logic [7:0] c);
        if (c >= ChDigit0 && c <= ChDigit9)
            return int'(c - ChDigit0);
        if (c >= ChLowerA && c <= ChLowerF)
            return int'(c - ChLowerA) + 10;
        if (c >= ChUpperA && c <= ChUpperF)
            return int'(c - ChUpperA) + 10;
        return -1;
    endfunction

    function automatic void emit(logic [7:0] b);
        dec_byte_t r;
        r.data     = b;
        r.run_last = 1'b0;
        r.str_end  = 1'b0;
        step_q = {step_q, r};
    endfunction

    // failed unicode escape: 'u' then the digits seen so far
    function automatic void flush_digits();
        emit(CharU);
        for (int k = 0; k < dig_count && k < 3; k++)
            emit(digits[k]);
    endfunction

    function automatic void plain_byte(logic [7:0] b, logic last);
        if (b == CharBackslash && !last)
            dec_mode = MODE_ESCAPE;
        else
            emit(b);
    endfunction

    // decode one accepted request and queue the bytes it yields
    function automatic void decode_step(logic [7:0] b, logic last);
        dec_byte_t tail;
        int        v;
        int        cval;
        step_q.delete();
        case (dec_mode)
            MODE_ESCAPE:
            begin
                dec_mode = MODE_PLAIN;
                if (b == CharN)
                    emit(CtrlLf);
                else if (b == CharT)
                    emit(CtrlHt);
                else if (b == CharR)
                    emit(CtrlCr);
                else if (b == CharB)
                    emit(CtrlBs);
                else if (b == CharF)
                    emit(CtrlFf);
                else if (b == CharU)
                begin
                    if (last)
                        emit(CharU);
                    else
                    begin
                        dec_mode  = MODE_HEX;
                        dig_count = 0;
                    end
                end
                else
                    emit(b);
            end
            MODE_HEX:
            begin
                v = hex_value(b);
                if (v < 0)
                begin
                    // non-hex byte ends the escape and is handled as plain text
                    flush_digits();
                    dec_mode  = MODE_PLAIN;
                    dig_count = 0;
                    plain_byte(b, last);
                end
                else if (dig_count < 3)
                begin
                    digits[dig_count] = b;
                    dig_count++;
                    if (last)
                    begin
                        flush_digits();
                        dec_mode  = MODE_PLAIN;
                        dig_count = 0;
                    end
                end
                else
                begin
                    cval = hex_value(digits[0]) * 4096 + hex_value(digits[1]) * 256
                         + hex_value(digits[2]) * 16 + v;
                    if (cval > 0 && cval < int'(AsciiLimit))
                        emit(cval[7:0]);
                    else
                    begin
                        flush_digits();
                        emit(b);
                    end
                    dec_mode  = MODE_PLAIN;
                    dig_count = 0;
                end
            end
            default:
            begin
                dec_mode = MODE_PLAIN;
                plain_byte(b, last);
            end
        endcase
        if (last)
        begin
            dec_mode  = MODE_PLAIN;
            dig_count = 0;
        end
        // mark the end of this group
        if (step_q.size() > 0)
        begin
            tail          = step_q[step_q.size() - 1];
            tail.run_last = 1'b1;
            tail.str_end  = last;
            step_q[step_q.size() - 1] = tail;
        end
        decoded_q = {decoded_q, step_q};
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10)
            return ChDigit0 + 8'(nib);
        return (($urandom_range(0, 1) == 1) ? ChUpperA : ChLowerA) + 8'(nib) - 8'd10;
    endfunction

    // occasionally a request waits until the core has drained
    function automatic void add_item(logic [7:0] b, logic last);
        esc_req_t r;
        r.data = b;
        r.last = last;
        r.hold = ($urandom_range(0, 49) == 0);
        escaped_q = {escaped_q, r};
    endfunction

    // request that always waits until every pending byte has come back
    function automatic void add_held(logic [7:0] b, logic last);
        esc_req_t r;
        r.data = b;
        r.last = last;
        r.hold = 1'b1;
        escaped_q = {escaped_q, r};
    endfunction

    function automatic void add_unicode(logic [15:0] code, logic end_str);
        add_item(CharBackslash, 1'b0);
        add_item(CharU, 1'b0);
        for (int i = 3; i >= 0; i--)
            add_item(hex_char(code[i*4 +: 4]), end_str && i == 0);
    endfunction

    function automatic logic [7:0] escape_char();
        case ($urandom_range(0, 8))
            0:       return CharN;
            1:       return CharT;
            2:       return CharR;
            3:       return CharB;
            4:       return CharF;
            5:       return ChQuote;
            6:       return CharBackslash;
            7:       return ChSlash;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one random token: plain byte, simple escape, unicode escape or broken escape
    function automatic void add_token();
        int         pick;
        int         k;
        logic       end_str;
        logic [7:0] b;
        pick    = $urandom_range(0, 99);
        end_str = ($urandom_range(0, 9) == 0);
        if (pick < 30)
            add_item(8'($urandom_range(0, 255)), end_str);
        else if (pick < 55)
        begin
            add_item(CharBackslash, 1'b0);
            add_item(escape_char(), end_str);
        end
        else if (pick < 78)
            add_unicode(16'($urandom_range(1, 127)), end_str);
        else if (pick < 88)
            add_unicode(($urandom_range(0, 2) == 0) ? 16'h0000
                        : 16'($urandom_range(128, 65535)), end_str);
        else
        begin
            k = $urandom_range(0, 3);
            add_item(CharBackslash, 1'b0);
            if ($urandom_range(0, 1) == 1)
            begin
                // escape that may be cut short by some other byte
                add_item(CharU, 1'b0);
                for (int i = 0; i < k; i++)
                    add_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
                b = ($urandom_range(0, 3) == 0) ? CharBackslash : 8'($urandom_range(0, 255));
                add_item(b, end_str);
            end
            else
            begin
                // string ends inside the escape
                add_item(CharU, k == 0);
                for (int i = 0; i < k; i++)
                    add_item(hex_char(4'($urandom_range(0, 15))), i == k - 1);
            end
        end
    endfunction

    function automatic void add_random(int n);
        int target;
        target = escaped_q.size() + n;
        while (escaped_q.size() < target)
            add_token();
    endfunction

    // ------------------------------------------------------------------
    // driver: predicts on acceptance, then presents the next request
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            in_last  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_step(in_byte, in_last);
            if (!in_valid || in_ready)
            begin
                if (escaped_q.size() > 0
                    && !(escaped_q[0].hold && decoded_q.size() > 0)
                    && $urandom_range(0, 99) >= send_idle)
                begin
                    next_req = escaped_q.pop_front();
                    in_valid <= 1'b1;
                    in_byte  <= next_req.data;
                    in_last  <= next_req.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    function automatic void note_failure(string msg);
        if (mismatch_count < 10)
            $display("%s", msg);
        mismatch_count++;
    endfunction

    // monitor: compare each decoded byte with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
                note_failure($sformatf("unexpected byte %02h run_last %0b string_end %0b",
                                       out_byte, run_last, string_end));
            else
            begin
                want = decoded_q.pop_front();
                if (out_byte !== want.data || run_last !== want.run_last
                    || string_end !== want.str_end)
                    note_failure($sformatf(
                        "mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                        want.data, want.run_last, want.str_end,
                        out_byte, run_last, string_end));
            end
        end
    end

    task automatic wait_drained(int tail_cycles);
        while (escaped_q.size() > 0 || in_valid || decoded_q.size() > 0)
            @(posedge clk);
        repeat (tail_cycles) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        // directed: extremes and each corner of the escape handling
        add_item(8'hFF, 1'b0);
        add_item(CharBackslash, 1'b0);
        add_item(8'h00, 1'b0);
        add_unicode(16'h007F, 1'b0);
        add_unicode(16'h0080, 1'b0);
        // sender waits for the five byte group to drain
        add_held(ChUpperA, 1'b0);
        // non-hex backslash inside unicode escape starts a new escape
        add_item(CharBackslash, 1'b0);
        add_item(CharU, 1'b0);
        add_item(ChUpperA, 1'b0);
        add_item(CharBackslash, 1'b0);
        add_item(CharN, 1'b0);
        // string ends with too few digits
        add_item(CharBackslash, 1'b0);
        add_item(CharU, 1'b0);
        add_item(ChDigit0 + 8'd1, 1'b1);
        // trailing backslash
        add_item(CharBackslash, 1'b1);
        // bare u at string end
        add_item(CharBackslash, 1'b0);
        add_item(CharU, 1'b1);
        add_random(100);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained(4);
        @(negedge clk);
        send_idle = 75;
        recv_idle = 10;
        add_random(100);

        wait_drained(4);
        @(negedge clk);
        send_idle = 0;
        recv_idle = 0;
        add_random(100);

        wait_drained(10);
        if (mismatch_count == 0 && decoded_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/jsu_pkg.sv
design/jsu_decode.sv
design/jsu_serializer.sv
design/json_string_unescape_core.sv
bench/json_string_unescape_core_test.sv
